[rtl/frpl_pkg.sv]
`timescale 1ns / 1ps

package frpl_pkg;

	localparam int FRAG_LEN_W = 12;

	localparam logic [7:0] CHAR_HEADER  = 8'h3E;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	typedef enum logic [1:0] {
		ACT_BYTE   = 2'd0,
		ACT_END    = 2'd1,
		ACT_LOCATE = 2'd2
	} frpl_action_t;

	typedef enum logic [2:0] {
		KIND_RESIDUE  = 3'd0,
		KIND_SEQ_END  = 3'd1,
		KIND_DEF_BYTE = 3'd2,
		KIND_DEF_END  = 3'd3,
		KIND_LOCATE   = 3'd4
	} frpl_kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_NOSEQ = 2'd1,
		STAT_FULL  = 2'd2
	} frpl_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK_FIRST,
		ST_RD_MID,
		ST_CHK_MID
	} frpl_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  data_byte;
		logic [31:0] position;
	} frpl_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  out_byte;
		logic [11:0] seq_index;
		logic [31:0] rel_pos;
		logic [12:0] seq_total;
		logic [31:0] residue_total;
		logic [31:0] fragment_total;
		logic [1:0]  status;
	} frpl_result_t;

endpackage

[rtl/fasta_record_parser_locator_unit.sv]
`timescale 1ns / 1ps

// FASTA parser with sequence locator.
// item channel (item_valid/item_ready/item): text bytes, end of stream, or locate
//   requests. result channel (result_valid/result_ready/result): at most one
//   result per request, held in an output register until taken.
// cfg channel (cfg_valid/cfg_ready/cfg_data): fragment length, always ready;
//   write it only while no request is in flight.
// byte and end-of-stream requests: the result is valid the cycle after
//   acceptance and a new request is taken in the same cycle the previous result
//   is taken, so a steady stream runs at one per cycle while results are taken.
// a locate request is a binary search over the start-offset memory, which has
//   one synchronous read port: the search steps through ST_CHK_FIRST, then
//   ST_RD_MID and ST_CHK_MID in turn, and no request is taken meanwhile.
// while the result register is full and result_ready is low, item_ready is
//   low; nothing is dropped.
// reset (arst_n low) clears the parser state, the counters and the sums and
//   sets the fragment length to 1; the start memory is not cleared, only
//   entries below seq_total are ever read.
module fasta_record_parser_locator_unit
	import frpl_pkg::*;
#(
	parameter int MAX_SEQUENCES = 4096,
	parameter int OFFSET_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  frpl_item_t            item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output frpl_result_t          result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [FRAG_LEN_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_SEQUENCES + 1);
	localparam int IDX_W = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
	localparam int CMP_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

	// start offset of each recorded sequence
	logic [OFFSET_BITS-1:0] start_mem [MAX_SEQUENCES];
	logic [OFFSET_BITS-1:0] rd_data_q;
	logic [IDX_W-1:0]       rd_addr;
	logic                   mem_we;

	frpl_state_t            state_q, state_d;
	logic                   line_start_q, line_start_d;
	logic                   in_header_q, in_header_d;
	logic                   header_seen_q, header_seen_d;
	logic [CNT_W-1:0]       seq_cnt_q, seq_cnt_d;
	logic [31:0]            cur_len_q, cur_len_d;
	logic [OFFSET_BITS-1:0] next_start_q, next_start_d;
	logic [31:0]            res_sum_q, res_sum_d;
	logic [31:0]            frag_sum_q, frag_sum_d;
	logic [FRAG_LEN_W-1:0]  frag_len_q;
	logic [IDX_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid;
	logic [OFFSET_BITS-1:0] lo_val_q, lo_val_d;
	logic [31:0]            pos_q, pos_d;
	frpl_result_t           result_q, res_d;
	logic                   result_valid_q, emit;

	logic                   item_fire;
	logic                   full;
	logic [CNT_W-1:0]       last_idx;
	logic [32:0]            res_add, frag_add;
	logic [31:0]            frag_inc;
	logic                   frag_ok;
	logic [31:0]            close_res, close_frag;
	logic [OFFSET_BITS-1:0] ns_inc;
	logic [CNT_W-1:0]       mid_w;
	logic                   first_miss, mid_hit, search_done;
	logic [IDX_W-1:0]       lo_n, hi_n;
	logic [OFFSET_BITS-1:0] lo_val_n;
	logic [CMP_W-1:0]       rel_w;

	assign item_fire = item_valid && item_ready;
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	assign full = (seq_cnt_q >= CNT_W'(MAX_SEQUENCES));
	assign last_idx = (seq_cnt_q != '0) ? seq_cnt_q - CNT_W'(1) : '0;

	// sequence close arithmetic, saturating sums
	assign res_add = {1'b0, res_sum_q} + {1'b0, cur_len_q};
	assign close_res = res_add[32] ? '1 : res_add[31:0];
	assign frag_ok = (cur_len_q >= 32'(frag_len_q));
	assign frag_inc = cur_len_q - 32'(frag_len_q) + 32'd1;
	assign frag_add = {1'b0, frag_sum_q} + {1'b0, frag_inc};
	assign close_frag = !frag_ok ? frag_sum_q : (frag_add[32] ? '1 : frag_add[31:0]);
	assign ns_inc = (next_start_q != '1) ? next_start_q + OFFSET_BITS'(1) : next_start_q;

	// search step
	assign mid_w = CNT_W'(lo_q)
		+ ((CNT_W'(hi_q) - CNT_W'(lo_q) + CNT_W'(1)) >> 1);
	assign mid = IDX_W'(mid_w);
	assign first_miss = (CMP_W'(rd_data_q) > CMP_W'(pos_q));
	assign mid_hit = (CMP_W'(rd_data_q) <= CMP_W'(pos_q));

	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		lo_val_n = lo_val_q;
		case (state_q)
			ST_CHK_FIRST: begin
				lo_val_n = rd_data_q;
			end
			ST_CHK_MID: begin
				if (mid_hit) begin
					lo_n = mid_q;
					lo_val_n = rd_data_q;
				end else begin
					hi_n = mid_q - IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign search_done = (lo_n == hi_n);
	assign rel_w = CMP_W'(pos_q) - CMP_W'(lo_val_n);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_fire && item.action == ACT_LOCATE && seq_cnt_q != '0)
					state_d = ST_CHK_FIRST;
			end
			ST_CHK_FIRST: begin
				if (first_miss || search_done)
					state_d = ST_IDLE;
				else
					state_d = ST_RD_MID;
			end
			ST_RD_MID: begin
				state_d = ST_CHK_MID;
			end
			ST_CHK_MID: begin
				state_d = search_done ? ST_IDLE : ST_RD_MID;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item_ready = (state_q == ST_IDLE) && (!result_valid_q || result_ready);
		rd_addr = (state_q == ST_RD_MID) ? mid : '0;
	end

	// parser and result formation
	always_comb begin
		line_start_d = line_start_q;
		in_header_d = in_header_q;
		header_seen_d = header_seen_q;
		seq_cnt_d = seq_cnt_q;
		cur_len_d = cur_len_q;
		next_start_d = next_start_q;
		res_sum_d = res_sum_q;
		frag_sum_d = frag_sum_q;
		lo_d = lo_n;
		hi_d = hi_n;
		lo_val_d = lo_val_n;
		pos_d = pos_q;
		mem_we = 1'b0;
		emit = 1'b0;
		res_d.result_kind = KIND_RESIDUE;
		res_d.out_byte = '0;
		res_d.seq_index = 12'(last_idx);
		res_d.rel_pos = '0;
		res_d.seq_total = 13'(seq_cnt_q);
		res_d.residue_total = res_sum_q;
		res_d.fragment_total = frag_sum_q;
		res_d.status = full ? STAT_FULL : STAT_OK;

		if (state_q == ST_IDLE && item_fire) begin
			case (item.action)
				ACT_BYTE: begin
					if (in_header_q) begin
						emit = 1'b1;
						if (item.data_byte == CHAR_NEWLINE) begin
							in_header_d = 1'b0;
							line_start_d = 1'b1;
							res_d.result_kind = KIND_DEF_END;
						end else begin
							res_d.result_kind = KIND_DEF_BYTE;
							res_d.out_byte = item.data_byte;
						end
					end else if (line_start_q && item.data_byte == CHAR_HEADER) begin
						if (header_seen_q) begin
							next_start_d = ns_inc;
							res_sum_d = close_res;
							frag_sum_d = close_frag;
							cur_len_d = '0;
							emit = 1'b1;
							res_d.result_kind = KIND_SEQ_END;
							res_d.residue_total = close_res;
							res_d.fragment_total = close_frag;
						end
						// table full: header parsed but not recorded
						if (!full) begin
							mem_we = 1'b1;
							seq_cnt_d = seq_cnt_q + CNT_W'(1);
						end
						header_seen_d = 1'b1;
						in_header_d = 1'b1;
						line_start_d = 1'b0;
					end else if (item.data_byte == CHAR_NEWLINE) begin
						line_start_d = 1'b1;
					end else begin
						line_start_d = 1'b0;
						// text before the first header is dropped
						if (header_seen_q) begin
							if (cur_len_q != '1)
								cur_len_d = cur_len_q + 32'd1;
							next_start_d = ns_inc;
							emit = 1'b1;
							res_d.result_kind = KIND_RESIDUE;
							res_d.out_byte = item.data_byte;
						end
					end
				end
				ACT_END: begin
					if (header_seen_q) begin
						next_start_d = ns_inc;
						res_sum_d = close_res;
						frag_sum_d = close_frag;
						cur_len_d = '0;
						emit = 1'b1;
						res_d.result_kind = KIND_SEQ_END;
						res_d.residue_total = close_res;
						res_d.fragment_total = close_frag;
					end
					header_seen_d = 1'b0;
					in_header_d = 1'b0;
					line_start_d = 1'b1;
				end
				ACT_LOCATE: begin
					if (seq_cnt_q == '0) begin
						emit = 1'b1;
						res_d.result_kind = KIND_LOCATE;
						res_d.seq_index = '0;
						res_d.status = STAT_NOSEQ;
					end else begin
						pos_d = item.position;
						lo_d = '0;
						hi_d = IDX_W'(last_idx);
					end
				end
				default: begin
				end
			endcase
		end else if ((state_q == ST_CHK_FIRST && (first_miss || search_done))
			|| (state_q == ST_CHK_MID && search_done)) begin
			emit = 1'b1;
			res_d.result_kind = KIND_LOCATE;
			if (state_q == ST_CHK_FIRST && first_miss) begin
				res_d.seq_index = '0;
				res_d.status = STAT_NOSEQ;
			end else begin
				res_d.seq_index = 12'(lo_n);
				res_d.rel_pos = rel_w[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			start_mem[seq_cnt_q[IDX_W-1:0]] <= next_start_d;
		rd_data_q <= start_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		lo_val_q <= lo_val_d;
		if (state_q == ST_RD_MID)
			mid_q <= mid;
		if (emit)
			result_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_start_q <= 1'b1;
			in_header_q <= 1'b0;
			header_seen_q <= 1'b0;
			seq_cnt_q <= '0;
			cur_len_q <= '0;
			next_start_q <= '0;
			res_sum_q <= '0;
			frag_sum_q <= '0;
			frag_len_q <= FRAG_LEN_W'(1);
			lo_q <= '0;
			hi_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			line_start_q <= line_start_d;
			in_header_q <= in_header_d;
			header_seen_q <= header_seen_d;
			seq_cnt_q <= seq_cnt_d;
			cur_len_q <= cur_len_d;
			next_start_q <= next_start_d;
			res_sum_q <= res_sum_d;
			frag_sum_q <= frag_sum_d;
			lo_q <= lo_d;
			hi_q <= hi_d;
			if (cfg_valid)
				frag_len_q <= cfg_data;
			if (emit)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	// the result register is empty for the whole of a search
	a_search_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !result_valid_q)
		else $error("result pending during locate search");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seq_cnt_q <= CNT_W'(MAX_SEQUENCES))
		else $error("sequence count beyond table depth");

	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_MID || state_q == ST_CHK_MID) |-> (lo_q < hi_q))
		else $error("search range collapsed without answer");

	a_store_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (next_start_q >= $past(next_start_q)))
		else $error("store fill went backwards");

	a_search_idle_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK_FIRST) |-> (seq_cnt_q != '0))
		else $error("locate search with empty table");

endmodule

[bench/frpl_parse_checker.sv]
`timescale 1ns / 1ps

module frpl_parse_checker
	import frpl_pkg::*;
#(
	parameter int MAX_SEQUENCES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  frpl_item_t            item,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  frpl_result_t          result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [FRAG_LEN_W-1:0] cfg_data,
	output int                    fail_count = 0,
	output int                    pending = 0
);

	// shadow parser state
	logic                  line_start = 1'b1;
	logic                  in_header = 1'b0;
	logic                  header_seen = 1'b0;
	logic [12:0]           seq_count = '0;
	logic [31:0]           cur_len = '0;
	logic [31:0]           store_fill = '0;
	logic [31:0]           residue_sum = '0;
	logic [31:0]           fragment_sum = '0;
	logic [FRAG_LEN_W-1:0] frag_len = 12'd1;
	logic [31:0]           start_offset [0:MAX_SEQUENCES-1];

	frpl_result_t expected_results [$];
	frpl_result_t want;
	frpl_result_t predicted;

	task automatic report_error(input string msg);
		$display("%0t ns  error: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_error($sformatf("%s got %0h, predicted %0h", name, got, exp_val));
	endtask

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [11:0] last_index();
		return (seq_count != 0) ? 12'(seq_count - 13'd1) : 12'd0;
	endfunction

	function automatic logic [1:0] full_status();
		return (seq_count >= MAX_SEQUENCES) ? STAT_FULL : STAT_OK;
	endfunction

	function automatic frpl_result_t result_now(input logic [2:0] kind,
			input logic [7:0] b, input logic [11:0] idx, input logic [31:0] rel,
			input logic [1:0] stat);
		frpl_result_t r;
		r.result_kind    = kind;
		r.out_byte       = b;
		r.seq_index      = idx;
		r.rel_pos        = rel;
		r.seq_total      = seq_count;
		r.residue_total  = residue_sum;
		r.fragment_total = fragment_sum;
		r.status         = stat;
		return r;
	endfunction

	function automatic void bump_store();
		if (store_fill != 32'hFFFF_FFFF)
			store_fill++;
	endfunction

	// terminator, sums, and fragment start positions of the closed sequence
	function automatic void close_sequence();
		bump_store();
		residue_sum = sat_add(residue_sum, cur_len);
		if (cur_len >= {20'd0, frag_len})
			fragment_sum = sat_add(fragment_sum, cur_len - {20'd0, frag_len} + 32'd1);
		cur_len = '0;
	endfunction

	function automatic bit parse_request(input frpl_item_t req, output frpl_result_t res);
		logic [7:0]  b;
		logic [31:0] pos;
		int          lo;
		int          hi;
		int          mid;
		bit          hit;
		b   = req.data_byte;
		pos = req.position;
		hit = 1'b0;
		res = '0;
		case (req.action)
			ACT_BYTE: begin
				if (in_header) begin
					if (b == CHAR_NEWLINE) begin
						in_header  = 1'b0;
						line_start = 1'b1;
						res = result_now(KIND_DEF_END, 8'd0, last_index(), '0, full_status());
					end else begin
						res = result_now(KIND_DEF_BYTE, b, last_index(), '0, full_status());
					end
					hit = 1'b1;
				end else if (line_start && b == CHAR_HEADER) begin
					if (header_seen) begin
						close_sequence();
						res = result_now(KIND_SEQ_END, 8'd0, last_index(), '0, full_status());
						hit = 1'b1;
					end
					// a header past a full table is parsed but not recorded
					if (seq_count < MAX_SEQUENCES) begin
						start_offset[seq_count] = store_fill;
						seq_count++;
					end
					header_seen = 1'b1;
					in_header   = 1'b1;
					line_start  = 1'b0;
				end else if (b == CHAR_NEWLINE) begin
					line_start = 1'b1;
				end else begin
					line_start = 1'b0;
					if (header_seen) begin
						if (cur_len != 32'hFFFF_FFFF)
							cur_len++;
						bump_store();
						res = result_now(KIND_RESIDUE, b, last_index(), '0, full_status());
						hit = 1'b1;
					end
				end
			end
			ACT_END: begin
				if (header_seen) begin
					close_sequence();
					res = result_now(KIND_SEQ_END, 8'd0, last_index(), '0, full_status());
					hit = 1'b1;
				end
				header_seen = 1'b0;
				in_header   = 1'b0;
				line_start  = 1'b1;
			end
			ACT_LOCATE: begin
				if (seq_count == 0 || start_offset[0] > pos) begin
					res = result_now(KIND_LOCATE, 8'd0, 12'd0, '0, STAT_NOSEQ);
				end else begin
					// last start at or below the position
					lo = 0;
					hi = int'(seq_count) - 1;
					while (lo < hi) begin
						mid = lo + (hi - lo + 1) / 2;
						if (start_offset[mid] <= pos)
							lo = mid;
						else
							hi = mid - 1;
					end
					res = result_now(KIND_LOCATE, 8'd0, 12'(lo), pos - start_offset[lo],
						full_status());
				end
				hit = 1'b1;
			end
			default: ;
		endcase
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start   = 1'b1;
			in_header    = 1'b0;
			header_seen  = 1'b0;
			seq_count    = '0;
			cur_len      = '0;
			store_fill   = '0;
			residue_sum  = '0;
			fragment_sum = '0;
			frag_len     = 12'd1;
			expected_results.delete();
			pending = 0;
		end else begin
			// a result never belongs to the request taken at the same edge
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_error($sformatf("result of kind %0d with none pending",
						result.result_kind));
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", 32'(result.result_kind), 32'(want.result_kind));
					check_field("out_byte", 32'(result.out_byte), 32'(want.out_byte));
					check_field("seq_index", 32'(result.seq_index), 32'(want.seq_index));
					check_field("rel_pos", result.rel_pos, want.rel_pos);
					check_field("seq_total", 32'(result.seq_total), 32'(want.seq_total));
					check_field("residue_total", result.residue_total, want.residue_total);
					check_field("fragment_total", result.fragment_total, want.fragment_total);
					check_field("status", 32'(result.status), 32'(want.status));
				end
			end
			if (cfg_valid && cfg_ready)
				frag_len = cfg_data;
			if (item_valid && item_ready) begin
				if (parse_request(item, predicted))
					expected_results.push_back(predicted);
			end
			pending = expected_results.size();
		end
	end

endmodule

[bench/fasta_record_parser_locator_unit_tb.sv]
`timescale 1ns / 1ps

module fasta_record_parser_locator_unit_tb;
	import frpl_pkg::*;

	localparam logic [1:0] ACT_UNUSED     = 2'd3;
	localparam int         RESULT_LATENCY = 40;
	localparam int         CYCLE_LIMIT    = 600000;
	localparam int         PHASE_ITEMS    = 200;
	localparam int         HOLD_CYCLES    = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	frpl_item_t            item = '0;
	logic                  result_valid;
	logic                  result_ready;
	frpl_result_t          result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [FRAG_LEN_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int hold_len = 0;
	int sent = 0;
	int cycle_count = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	always #1 clk = ~clk;

	fasta_record_parser_locator_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	frpl_parse_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// called and returning at a falling edge
	task automatic send_request(input logic [1:0] act, input logic [7:0] b,
			input logic [31:0] pos);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		item_valid     <= 1'b1;
		item.action    <= act;
		item.data_byte <= b;
		item.position  <= pos;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		if (act != ACT_UNUSED)
			sent++;
	endtask

	// wait out every pending result plus the no-result requests in flight
	task automatic settle();
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_fragment_length(input logic [FRAG_LEN_W-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] text_byte(input bit line_head);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CHAR_NEWLINE || (line_head && b == CHAR_HEADER));
		return b;
	endfunction

	function automatic logic [31:0] pick_position();
		return ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1500));
	endfunction

	// one FASTA record; a broken one stops early and ends the stream
	task automatic send_record(input bit broken);
		int hdr_len;
		int nlines;
		int len;
		int k;
		int j;
		hdr_len = $urandom_range(0, 6);
		nlines  = $urandom_range(0, 3);
		send_request(ACT_BYTE, CHAR_HEADER, 32'($urandom));
		for (k = 0; k < hdr_len; k++)
			send_request(ACT_BYTE, text_byte(1'b0), 32'($urandom));
		if (broken && $urandom_range(0, 1) == 0) begin
			send_request(ACT_END, 8'($urandom), 32'($urandom));
			return;
		end
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'($urandom));
		for (k = 0; k < nlines; k++) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 14);
			for (j = 0; j < len; j++)
				send_request(ACT_BYTE, text_byte(j == 0), 32'($urandom));
			if (!(broken && k == nlines - 1))
				send_request(ACT_BYTE, CHAR_NEWLINE, 32'($urandom));
		end
		if (broken)
			send_request(ACT_END, 8'($urandom), 32'($urandom));
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_request(ACT_BYTE, 8'($urandom), 32'($urandom));
			1: send_request(ACT_END, 8'($urandom), 32'($urandom));
			2: send_request(ACT_LOCATE, 8'($urandom), pick_position());
			default: send_request(ACT_UNUSED, 8'($urandom), 32'($urandom));
		endcase
	endtask

	// receiver side: random stalls, or a long hold-off when asked for
	initial begin
		int n;
		result_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_len != 0) begin
				n = hold_len;
				hold_len = 0;
				result_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [FRAG_LEN_W-1:0] frag_set [5];
		int p;
		int i;
		int goal;
		frag_set[0] = 12'd0;
		frag_set[1] = 12'd4095;
		frag_set[2] = 12'd3;
		frag_set[3] = 12'($urandom_range(1, 40));
		frag_set[4] = 12'($urandom);
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, ignored requests, stray text, header edge cases
		send_request(ACT_LOCATE, 8'd0, 32'd0);
		send_request(ACT_LOCATE, 8'd0, 32'hFFFF_FFFF);
		send_request(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		send_request(ACT_END, 8'd0, 32'd0);
		send_request(ACT_BYTE, "A", 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		send_request(ACT_BYTE, CHAR_HEADER, 32'd0);
		send_request(ACT_BYTE, "h", 32'd0);
		send_request(ACT_BYTE, CHAR_HEADER, 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		send_request(ACT_BYTE, 8'h00, 32'd0);
		send_request(ACT_BYTE, 8'hFF, 32'd0);
		send_request(ACT_BYTE, CHAR_HEADER, 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		send_request(ACT_BYTE, CHAR_HEADER, 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		send_request(ACT_BYTE, CHAR_HEADER, 32'd0);
		send_request(ACT_BYTE, "x", 32'd0);
		send_request(ACT_END, 8'd0, 32'd0);
		send_request(ACT_LOCATE, 8'd0, 32'd2);
		send_request(ACT_LOCATE, 8'd0, 32'hFFFF_FFFF);
		send_request(ACT_LOCATE, 8'd0, 32'd0);
		send_request(ACT_BYTE, "Z", 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);

		// random records under several fragment lengths
		for (p = 0; p < 5; p++) begin
			settle();
			set_fragment_length(frag_set[p]);
			tx_idle = (p != 1);
			rx_idle = (p != 1 && p != 3);
			if (p == 2)
				hold_len = HOLD_CYCLES;
			goal = sent + PHASE_ITEMS;
			while (sent < goal) begin
				if ($urandom_range(0, 5) == 0)
					send_noise();
				else
					send_record($urandom_range(0, 7) == 0);
				if ($urandom_range(0, 2) == 0)
					send_request(ACT_LOCATE, 8'($urandom), pick_position());
			end
		end

		// no idling from here on: long sequence, stray text, a late header
		settle();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		set_fragment_length(12'd120);
		send_request(ACT_BYTE, CHAR_HEADER, 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		for (i = 0; i < 130; i++) begin
			send_request(ACT_BYTE, text_byte(i % 60 == 0), 32'd0);
			if (i % 60 == 59)
				send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		end
		send_request(ACT_END, 8'd0, 32'd0);
		send_request(ACT_LOCATE, 8'd0, pick_position());
		send_request(ACT_BYTE, "q", 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		for (i = 0; i < 12; i++)
			send_request(ACT_BYTE, text_byte(i == 0), 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		send_request(ACT_BYTE, CHAR_HEADER, 32'd0);
		send_request(ACT_BYTE, "r", 32'd0);
		send_request(ACT_BYTE, CHAR_NEWLINE, 32'd0);
		for (i = 0; i < 6; i++)
			send_request(ACT_LOCATE, 8'd0, pick_position());
		send_request(ACT_LOCATE, 8'd0, 32'hFFFF_FFFF);
		send_request(ACT_LOCATE, 8'd0, 32'd0);
		send_request(ACT_END, 8'd0, 32'd0);

		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (RESULT_LATENCY) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
rtl/frpl_pkg.sv
rtl/fasta_record_parser_locator_unit.sv
bench/frpl_parse_checker.sv
bench/fasta_record_parser_locator_unit_tb.sv
